// ----- design/pwl_pkg.sv -----
// ----------------------------------------------------------------------------
// pwl_pkg: shared types and constants for the pulse width latch driver
// Command codes, register indexes, beat payload structs and the job record
// passed from the command stage to the serializer.
// ----------------------------------------------------------------------------
package pwl_pkg;

	localparam int unsigned CmdW     = 3;
	localparam int unsigned PosW     = 3;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned LowW     = 16;
	localparam int unsigned CfgIdxW  = 2;

	typedef enum logic [CmdW-1:0] {
		CMD_SET_BIT    = 3'd0,
		CMD_CLEAR_BIT  = 3'd1,
		CMD_WRITE_BYTE = 3'd2,
		CMD_RESET      = 3'd3,
		CMD_START_HOLD = 3'd4,
		CMD_FLUSH      = 3'd5
	} cmd_e;

	localparam logic [CfgIdxW-1:0] REG_SHORT_LOW = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_LONG_LOW  = 2'd1;

	localparam logic [LowW-1:0] SHORT_LOW_RST = 16'd4;
	localparam logic [LowW-1:0] LONG_LOW_RST  = 16'd100;

	localparam logic [PosW-1:0] POS_FIRST = 3'd7;
	localparam logic [PosW-1:0] POS_LAST  = 3'd0;

	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic [PosW-1:0]  bit_index;
		logic [ByteW-1:0] byte_value;
	} in_beat_t;

	typedef struct packed {
		logic             pulse_valid;
		logic             serial_bit;
		logic [LowW-1:0]  low_time;
		logic [PosW-1:0]  bit_position;
		logic [ByteW-1:0] shadow_state;
		logic             last;
	} out_beat_t;

	// one decoded command waiting for the serializer
	typedef struct packed {
		logic             send;
		logic [ByteW-1:0] shadow;
	} job_t;

endpackage

// ----- design/pulse_width_latch_output_driver.sv -----
// ----------------------------------------------------------------------------
// pulse_width_latch_output_driver: shadow latch byte sent as pulse widths
// Input channel (in_valid/in_ready/in_data) takes one command per beat.
// Each command may update the shadow byte or the hold flag; if the line must
// be refreshed, the shadow goes out MSB first as eight pulse beats (short
// low time for a one, long for a zero), otherwise one status beat follows.
// The last beat of each command carries last = 1.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 sets the short low time, index 1 the long one, others are ignored.
// A command beat is registered as a job in the command stage and then loaded
// into the serializer output register. One result beat goes out per cycle
// while the receiver is ready, eight for a refresh and one for a status
// command; a new command is taken while the previous one is still serialized.
// Reset clears shadow, sent byte and hold flag, low times return to 4/100.
// When the receiver stalls, the output beat holds and the command stage
// backs up by one job before in_ready drops.
// ----------------------------------------------------------------------------
module pulse_width_latch_output_driver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pwl_pkg::in_beat_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pwl_pkg::out_beat_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pwl_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [pwl_pkg::LowW-1:0]    cfg_data
);
	import pwl_pkg::*;

	logic [LowW-1:0] short_low_q;
	logic [LowW-1:0] long_low_q;
	logic            job_valid;
	logic            job_ready;
	job_t            job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_low_q <= SHORT_LOW_RST;
			long_low_q  <= LONG_LOW_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SHORT_LOW) begin
				short_low_q <= cfg_data;
			end else if (cfg_index == REG_LONG_LOW) begin
				long_low_q <= cfg_data;
			end
		end
	end

	pwl_cmd u_cmd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	pwl_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.short_low (short_low_q),
		.long_low  (long_low_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- design/pwl_cmd.sv -----
// ----------------------------------------------------------------------------
// pwl_cmd: command stage
// Applies each command to the shadow byte and hold flag, decides whether the
// shadow goes out on the line, and registers the job for the serializer.
// ----------------------------------------------------------------------------
module pwl_cmd (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pwl_pkg::in_beat_t in_data,
	output logic             job_valid,
	input  logic             job_ready,
	output pwl_pkg::job_t    job
);
	import pwl_pkg::*;

	logic [ByteW-1:0] shadow_q;
	logic [ByteW-1:0] sent_q;
	logic             hold_q;
	logic             job_valid_s1;
	job_t             job_s1;

	logic [ByteW-1:0] shadow_n;
	logic             hold_n;
	logic             may_send;
	logic             send;
	logic [ByteW-1:0] bit_mask;
	logic             accept;

	assign bit_mask = ByteW'(1) << in_data.bit_index;
	assign accept   = in_valid && in_ready;
	assign in_ready = !job_valid_s1 || job_ready;

	always_comb begin
		shadow_n = shadow_q;
		hold_n   = hold_q;
		may_send = 1'b1;
		case (in_data.command)
			CMD_SET_BIT:    shadow_n = shadow_q | bit_mask;
			CMD_CLEAR_BIT:  shadow_n = shadow_q & ~bit_mask;
			CMD_WRITE_BYTE: shadow_n = in_data.byte_value;
			CMD_RESET: begin
				shadow_n = '0;
				hold_n   = 1'b0;
			end
			CMD_START_HOLD: begin
				hold_n   = 1'b1;
				may_send = 1'b0;
			end
			CMD_FLUSH:      hold_n = 1'b0;
			default:        may_send = 1'b0;
		endcase
		send = may_send && !hold_n && (shadow_n != sent_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q     <= '0;
			sent_q       <= '0;
			hold_q       <= 1'b0;
			job_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				shadow_q     <= shadow_n;
				hold_q       <= hold_n;
				job_valid_s1 <= 1'b1;
				if (send) begin
					sent_q <= shadow_n;
				end
			end else if (job_ready) begin
				job_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.send   <= send;
			job_s1.shadow <= shadow_n;
		end
	end

	assign job_valid = job_valid_s1;
	assign job       = job_s1;

endmodule

// ----- design/pwl_ser.sv -----
// ----------------------------------------------------------------------------
// pwl_ser: pulse serializer
// Turns a job into eight pulse beats, MSB first, or one status beat, held in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module pwl_ser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	output logic                     job_ready,
	input  pwl_pkg::job_t            job,
	input  logic [pwl_pkg::LowW-1:0] short_low,
	input  logic [pwl_pkg::LowW-1:0] long_low,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pwl_pkg::out_beat_t       out_data
);
	import pwl_pkg::*;

	logic             out_valid_q;
	out_beat_t        out_q;
	logic [ByteW-1:0] byte_q;

	logic             load;
	logic             advance;
	logic [PosW-1:0]  pos_next;
	logic             bit_first;
	logic             bit_next;

	assign job_ready = !out_valid_q || (out_ready && out_q.last);
	assign load      = job_valid && job_ready;
	assign advance   = out_valid_q && out_ready && !out_q.last;
	assign pos_next  = out_q.bit_position - PosW'(1);
	assign bit_first = job.shadow[POS_FIRST];
	assign bit_next  = byte_q[pos_next];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job_ready) begin
			out_valid_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q             <= job.shadow;
			out_q.shadow_state <= job.shadow;
			if (job.send) begin
				out_q.pulse_valid  <= 1'b1;
				out_q.serial_bit   <= bit_first;
				out_q.low_time     <= bit_first ? short_low : long_low;
				out_q.bit_position <= POS_FIRST;
				out_q.last         <= 1'b0;
			end else begin
				out_q.pulse_valid  <= 1'b0;
				out_q.serial_bit   <= 1'b0;
				out_q.low_time     <= '0;
				out_q.bit_position <= POS_LAST;
				out_q.last         <= 1'b1;
			end
		end else if (advance) begin
			out_q.serial_bit   <= bit_next;
			out_q.low_time     <= bit_next ? short_low : long_low;
			out_q.bit_position <= pos_next;
			out_q.last         <= (pos_next == POS_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/pwl_chk.sv -----
// ----------------------------------------------------------------------------
// pwl_chk: port level checks for the pulse width latch driver
// Watches the result channel for well formed pulse sequences and status beats.
// ----------------------------------------------------------------------------
module pwl_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input pwl_pkg::out_beat_t out_data
);
	import pwl_pkg::*;

	// pulses of one command come back to back, counting down
	a_pulse_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.pulse_valid && !out_data.last |=>
		out_valid && out_data.pulse_valid &&
		out_data.bit_position == PosW'($past(out_data.bit_position) - PosW'(1)))
		else $error("pulse sequence broken");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pulse_valid |->
		out_data.last && out_data.low_time == '0 && out_data.bit_position == '0 &&
		!out_data.serial_bit)
		else $error("malformed status beat");

	a_pulse_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pulse_valid |->
		out_data.last == (out_data.bit_position == POS_LAST))
		else $error("last flag does not match bit position");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

endmodule

bind pulse_width_latch_output_driver pwl_chk u_pwl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- dv/pwl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_checker: result predictor and scoreboard for the pulse width driver
// Watches the command, config and result channels. Every accepted command
// is run through a local copy of the shadow, sent byte, hold flag and low
// times; the beats it should cause are queued and each accepted result beat
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pwl_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  pwl_pkg::in_beat_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  pwl_pkg::out_beat_t          out_data,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [pwl_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [pwl_pkg::LowW-1:0]    cfg_data,
	output int                          fail_count,
	output int                          pending
);
	import pwl_pkg::*;

	logic [LowW-1:0]  short_low;
	logic [LowW-1:0]  long_low;
	logic [ByteW-1:0] shadow;
	logic [ByteW-1:0] sent;
	logic             hold;

	out_beat_t line_beats_q[$];

	function automatic void queue_line_beats(in_beat_t cmd);
		logic             may_send;
		logic [ByteW-1:0] mask;
		out_beat_t        beat;
		int               p;
		may_send = 1'b1;
		mask = 8'b1 << cmd.bit_index;
		case (cmd.command)
			CMD_SET_BIT:    shadow = shadow | mask;
			CMD_CLEAR_BIT:  shadow = shadow & ~mask;
			CMD_WRITE_BYTE: shadow = cmd.byte_value;
			CMD_RESET: begin
				shadow = '0;
				hold = 1'b0;
			end
			CMD_START_HOLD: begin
				hold = 1'b1;
				may_send = 1'b0;
			end
			CMD_FLUSH:      hold = 1'b0;
			default:        may_send = 1'b0;
		endcase
		if (may_send && !hold && shadow != sent) begin
			// msb goes down the line first
			for (p = int'(POS_FIRST); p >= int'(POS_LAST); p--) begin
				beat.pulse_valid  = 1'b1;
				beat.serial_bit   = shadow[p];
				beat.low_time     = shadow[p] ? short_low : long_low;
				beat.bit_position = p[PosW-1:0];
				beat.shadow_state = shadow;
				beat.last         = (p == int'(POS_LAST));
				line_beats_q.push_back(beat);
			end
			sent = shadow;
		end else begin
			beat = '0;
			beat.shadow_state = shadow;
			beat.last = 1'b1;
			line_beats_q.push_back(beat);
		end
	endfunction

	function automatic void check_field(string name, logic [LowW-1:0] want,
		logic [LowW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_low = SHORT_LOW_RST;
			long_low = LONG_LOW_RST;
			shadow = '0;
			sent = '0;
			hold = 1'b0;
			line_beats_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHORT_LOW: short_low = cfg_data;
					REG_LONG_LOW:  long_low = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (line_beats_q.size() == 0) begin
					$error("result beat with nothing expected: shadow_state %0h",
						out_data.shadow_state);
					fail_count++;
				end else begin
					out_beat_t want;
					want = line_beats_q.pop_front();
					check_field("pulse_valid", LowW'(want.pulse_valid),
						LowW'(out_data.pulse_valid));
					check_field("serial_bit", LowW'(want.serial_bit),
						LowW'(out_data.serial_bit));
					check_field("low_time", want.low_time, out_data.low_time);
					check_field("bit_position", LowW'(want.bit_position),
						LowW'(out_data.bit_position));
					check_field("shadow_state", LowW'(want.shadow_state),
						LowW'(out_data.shadow_state));
					check_field("last", LowW'(want.last), LowW'(out_data.last));
				end
			end
			if (in_valid && in_ready)
				queue_line_beats(in_data);
			pending = line_beats_q.size();
		end
	end

endmodule

// ----- dv/pulse_width_latch_output_driver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_latch_output_driver_tb: command stream test of the driver
// Drives a directed run of latch commands and then random phases under
// several low time settings, with bursty command traffic, a stalling
// receiver, one long receiver hold-off and a drain after each phase. Checking
// is done by pwl_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module pulse_width_latch_output_driver_tb;
	import pwl_pkg::*;

	// codes the package leaves unnamed
	localparam logic [CmdW-1:0]    CMD_SPARE_LO = 3'd6;
	localparam logic [CmdW-1:0]    CMD_SPARE_HI = 3'd7;
	localparam logic [CfgIdxW-1:0] REG_SPARE_A  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SPARE_B  = 2'd3;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_STALL     = 400;
	localparam int SETTLE_CYCLES  = 10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_beat_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_beat_t          out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [LowW-1:0]    cfg_data = '0;

	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	int   burst_left = 0;
	logic long_stall_go = 1'b0;

	always #1 clk = ~clk;

	pulse_width_latch_output_driver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwl_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic in_beat_t make_cmd(logic [CmdW-1:0] code, logic [PosW-1:0] idx,
		logic [ByteW-1:0] value);
		in_beat_t b;
		b.command = code;
		b.bit_index = idx;
		b.byte_value = value;
		return b;
	endfunction

	function automatic logic [PosW-1:0] rand_pos();
		return PosW'($urandom_range(0, 7));
	endfunction

	function automatic logic [ByteW-1:0] rand_byte();
		return ByteW'($urandom_range(0, 255));
	endfunction

	function automatic in_beat_t random_bit_cmd();
		return make_cmd($urandom_range(0, 1) ? CMD_SET_BIT : CMD_CLEAR_BIT,
			rand_pos(), rand_byte());
	endfunction

	// one command beat, with a random gap whenever a burst runs out
	task automatic send_cmd(in_beat_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [LowW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_low_times(logic [LowW-1:0] short_v, logic [LowW-1:0] long_v);
		cfg_write(REG_SHORT_LOW, short_v);
		cfg_write(REG_LONG_LOW, long_v);
	endtask

	task automatic run_directed();
		send_cmd(make_cmd(CMD_WRITE_BYTE, 3'd0, 8'h00));  // no change, status only
		send_cmd(make_cmd(CMD_WRITE_BYTE, 3'd7, 8'hFF));
		send_cmd(make_cmd(CMD_WRITE_BYTE, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_WRITE_BYTE, 3'd5, 8'hA5));
		send_cmd(make_cmd(CMD_CLEAR_BIT, 3'd7, 8'hFF));
		send_cmd(make_cmd(CMD_SET_BIT, 3'd1, 8'h00));
		send_cmd(make_cmd(CMD_SET_BIT, 3'd1, 8'h00));
		send_cmd(make_cmd(CMD_CLEAR_BIT, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_SET_BIT, 3'd0, 8'hFF));
		// held: changes pile up in the shadow
		send_cmd(make_cmd(CMD_START_HOLD, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_SET_BIT, 3'd7, 8'h00));
		send_cmd(make_cmd(CMD_WRITE_BYTE, 3'd0, 8'h5A));
		send_cmd(make_cmd(CMD_START_HOLD, 3'd7, 8'hFF));
		send_cmd(make_cmd(CMD_FLUSH, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_FLUSH, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_RESET, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_RESET, 3'd7, 8'hFF));
		send_cmd(make_cmd(CMD_SPARE_LO, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_SPARE_HI, 3'd7, 8'hFF));
		// reset drops a hold without sending when nothing changed
		send_cmd(make_cmd(CMD_START_HOLD, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_RESET, 3'd0, 8'h00));
		send_cmd(make_cmd(CMD_SET_BIT, 3'd3, 8'h00));
		send_cmd(make_cmd(CMD_CLEAR_BIT, 3'd3, 8'hFF));
		send_cmd(make_cmd(CMD_SET_BIT, 3'd7, 8'h00));
	endtask

	task automatic run_random(int n);
		int done;
		int pick;
		int k;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_cmd(make_cmd(CMD_WRITE_BYTE, rand_pos(), rand_byte()));
				done++;
			end else if (pick < 60) begin
				send_cmd(random_bit_cmd());
				done++;
			end else if (pick < 75) begin
				// hold, a few edits, then release
				k = $urandom_range(1, 4);
				send_cmd(make_cmd(CMD_START_HOLD, rand_pos(), rand_byte()));
				repeat (k) send_cmd(random_bit_cmd());
				send_cmd(make_cmd($urandom_range(0, 3) ? CMD_FLUSH : CMD_RESET,
					rand_pos(), rand_byte()));
				done += k + 2;
			end else if (pick < 82) begin
				send_cmd(make_cmd(CMD_RESET, rand_pos(), rand_byte()));
				done++;
			end else if (pick < 88) begin
				send_cmd(make_cmd(CMD_FLUSH, rand_pos(), rand_byte()));
				done++;
			end else if (pick < 94) begin
				send_cmd(make_cmd(CMD_START_HOLD, rand_pos(), rand_byte()));
				done++;
			end else begin
				send_cmd(make_cmd($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI,
					rand_pos(), rand_byte()));
				done++;
			end
		end
	endtask

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (long_stall_go) begin
				long_stall_go = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_STALL - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				tick++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((tick % 5) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("pulse_width_latch_output_driver test failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain_results();

		set_low_times(16'd1, 16'hFFFF);
		cfg_write(REG_SPARE_A, 16'h0000);
		cfg_write(REG_SPARE_B, 16'hFFFF);
		run_random(30);
		drain_results();

		// receiver holds off while commands keep coming
		set_low_times(16'hFFFF, 16'd1);
		run_random(20);
		long_stall_go = 1'b1;
		run_random(20);
		drain_results();

		set_low_times(16'd0, 16'd0);
		run_random(20);
		drain_results();
		run_random(20);
		drain_results();

		set_low_times(LowW'($urandom_range(0, 65535)), LowW'($urandom_range(0, 65535)));
		run_random(30);
		drain_results();

		if (fail_count == 0 && pending == 0)
			$display("pulse_width_latch_output_driver test passed");
		else
			$display("pulse_width_latch_output_driver test failed");
		$finish;
	end

endmodule
